[rtl/dfp_pkg.sv]
package dfp_pkg;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [1:0] REG_PACING_MODE = 2'd0;
  localparam logic [1:0] REG_PERIOD_NS   = 2'd1;
  localparam logic [1:0] REG_SINK_OPEN   = 2'd2;

  localparam logic MODE_WALLCLOCK = 1'b0;
  localparam logic MODE_FREE      = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOT_OPEN = 2'd1,
    STATUS_INVALID  = 2'd2
  } status_t;

  typedef struct packed {
    logic [62:0] arrival_ns;
    logic [31:0] held_us;
    logic        frame_valid;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        consumed;
    logic [47:0] consumed_total;
    logic [47:0] dropped_total;
    logic [62:0] latency_sum_us;
    logic [47:0] latency_count;
    logic [31:0] latency_peak_us;
  } out_item_t;

  typedef struct packed {
    logic        pacing_mode;
    logic [31:0] period_ns;
    logic        sink_open;
    logic        clear_all;
    logic        unanchor;
  } cfg_ctrl_t;

endpackage

[rtl/deadline_frame_pacer.sv]
// Path: an accepted beat goes into the input register, then into the result register.
// Throughput: one beat per cycle while out_stall does not hold the result register;
// the decision, deadline add/compare and saturating counters all settle between
// the two registers.
// Reset: synchronous active-low rst_n clears the valid flags, anchor and statistics.
module deadline_frame_pacer
  import dfp_pkg::*;
#(
  parameter int COUNTER_BITS = 48,
  parameter int TIME_BITS    = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_ctrl_t ctrl;
  out_item_t core_result;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;

  dfp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl    (ctrl)
  );

  dfp_core #(
    .COUNTER_BITS (COUNTER_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .advance (advance),
    .item    (in_item_r),
    .result  (core_result)
  );

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= core_result;
    end
  end

  a_advance_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed beat did not reach the result register");

  a_consume_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.consumed) |-> (out_data.status == STATUS_OK))
    else $error("frame consumed with an error status");

  a_error_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (core_result.status != STATUS_OK)) |-> !core_result.consumed)
    else $error("rejected frame marked consumed");

endmodule

[rtl/dfp_cfg.sv]
module dfp_cfg
  import dfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_ctrl_t                ctrl
);

  logic        pacing_mode_r;
  logic [31:0] period_ns_r;
  logic        sink_open_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pacing_mode_r <= 1'b0;
      period_ns_r   <= '0;
      sink_open_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PACING_MODE: pacing_mode_r <= pwdata[0];
        REG_PERIOD_NS:   period_ns_r   <= pwdata[31:0];
        REG_SINK_OPEN:   sink_open_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PACING_MODE: prdata = {31'd0, pacing_mode_r};
      REG_PERIOD_NS:   prdata = period_ns_r;
      REG_SINK_OPEN:   prdata = {31'd0, sink_open_r};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    ctrl.pacing_mode = pacing_mode_r;
    ctrl.period_ns   = period_ns_r;
    ctrl.sink_open   = sink_open_r;
    ctrl.clear_all   = wr_en && (reg_idx == REG_SINK_OPEN) && pwdata[0];
    ctrl.unanchor    = wr_en && (reg_idx == REG_SINK_OPEN) && !pwdata[0];
  end

endmodule

[rtl/dfp_core.sv]
module dfp_core
  import dfp_pkg::*;
#(
  parameter int COUNTER_BITS = 48,
  parameter int TIME_BITS    = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_ctrl_t ctrl,
  input  logic      advance,
  input  in_item_t  item,
  output out_item_t result
);

  logic                    anchored_r;
  logic [TIME_BITS-1:0]    deadline_r;
  logic [COUNTER_BITS-1:0] consumed_r;
  logic [COUNTER_BITS-1:0] dropped_r;
  logic [62:0]             lat_sum_r;
  logic [COUNTER_BITS-1:0] samples_r;
  logic [31:0]             peak_r;

  logic                    anchored_nxt;
  logic [TIME_BITS-1:0]    deadline_nxt;
  logic [COUNTER_BITS-1:0] consumed_nxt;
  logic [COUNTER_BITS-1:0] dropped_nxt;
  logic [62:0]             lat_sum_nxt;
  logic [COUNTER_BITS-1:0] samples_nxt;
  logic [31:0]             peak_nxt;

  logic [TIME_BITS-1:0] arrival;
  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS-1:0] arr_plus;
  logic [TIME_BITS-1:0] cand;
  logic                 reached;
  logic                 consume;
  logic                 work;
  logic [63:0]          lat_add;
  status_t              status;

  assign arrival  = TIME_BITS'(item.arrival_ns);
  assign period   = TIME_BITS'(ctrl.period_ns);
  assign arr_plus = arrival + period;
  assign cand     = deadline_r + period;
  assign reached  = arrival >= deadline_r;
  assign lat_add  = {1'b0, lat_sum_r} + 64'(item.held_us);

  always_comb begin
    priority if (!ctrl.sink_open) begin
      status = STATUS_NOT_OPEN;
    end else if (!item.frame_valid) begin
      status = STATUS_INVALID;
    end else begin
      status = STATUS_OK;
    end
    work    = (status == STATUS_OK);
    consume = work && ((ctrl.pacing_mode == MODE_FREE) || !anchored_r || reached);

    anchored_nxt = anchored_r;
    deadline_nxt = deadline_r;
    consumed_nxt = consumed_r;
    dropped_nxt  = dropped_r;
    lat_sum_nxt  = lat_sum_r;
    samples_nxt  = samples_r;
    peak_nxt     = peak_r;

    if (work) begin
      if (ctrl.pacing_mode == MODE_WALLCLOCK) begin
        priority if (!anchored_r) begin
          deadline_nxt = arr_plus;
        end else if (reached) begin
          deadline_nxt = (cand <= arrival) ? arr_plus : cand;
        end else begin
          deadline_nxt = deadline_r;
        end
      end
      if (consume) begin
        anchored_nxt = 1'b1;
        consumed_nxt = (consumed_r == '1) ? consumed_r : consumed_r + 1'b1;
      end else begin
        dropped_nxt = (dropped_r == '1) ? dropped_r : dropped_r + 1'b1;
      end
      lat_sum_nxt = lat_add[63] ? '1 : lat_add[62:0];
      samples_nxt = (samples_r == '1) ? samples_r : samples_r + 1'b1;
      if (item.held_us > peak_r) begin
        peak_nxt = item.held_us;
      end
    end

    result.status          = status;
    result.consumed        = consume;
    result.consumed_total  = 48'(consumed_nxt);
    result.dropped_total   = 48'(dropped_nxt);
    result.latency_sum_us  = lat_sum_nxt;
    result.latency_count   = 48'(samples_nxt);
    result.latency_peak_us = peak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_all) begin
      anchored_r <= 1'b0;
      deadline_r <= '0;
      consumed_r <= '0;
      dropped_r  <= '0;
      lat_sum_r  <= '0;
      samples_r  <= '0;
      peak_r     <= '0;
    end else if (ctrl.unanchor) begin
      anchored_r <= 1'b0;
    end else if (advance) begin
      anchored_r <= anchored_nxt;
      deadline_r <= deadline_nxt;
      consumed_r <= consumed_nxt;
      dropped_r  <= dropped_nxt;
      lat_sum_r  <= lat_sum_nxt;
      samples_r  <= samples_nxt;
      peak_r     <= peak_nxt;
    end
  end

endmodule

[tb/sv/pacer_checker.sv]
module pacer_checker
  import dfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output int                       mismatches,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        pace_mode;
  logic [31:0] period;
  logic        sink_is_open;

  logic        anchored;
  logic [63:0] deadline;
  logic [47:0] n_consumed;
  logic [47:0] n_dropped;
  logic [62:0] hold_sum;
  logic [47:0] n_samples;
  logic [31:0] hold_peak;

  out_item_t   due_results[$];
  out_item_t   want;

  task automatic clear_stats();
    anchored   = 1'b0;
    deadline   = '0;
    n_consumed = '0;
    n_dropped  = '0;
    hold_sum   = '0;
    n_samples  = '0;
    hold_peak  = '0;
  endtask

  function automatic logic [47:0] bump(input logic [47:0] v);
    return (&v) ? v : v + 48'd1;
  endfunction

  function automatic out_item_t pace_frame(input in_item_t f);
    out_item_t   r;
    logic [63:0] t;
    logic [63:0] next_t;
    logic        take;
    t        = {1'b0, f.arrival_ns};
    take     = 1'b0;
    r.status = STATUS_OK;
    if (!sink_is_open) begin
      r.status = STATUS_NOT_OPEN;
    end else if (!f.frame_valid) begin
      r.status = STATUS_INVALID;
    end else begin
      if (pace_mode == MODE_FREE) begin
        take = 1'b1;
      end else if (!anchored) begin
        deadline = t + 64'(period);
        take     = 1'b1;
      end else if (t >= deadline) begin
        next_t   = deadline + 64'(period);
        take     = 1'b1;
        deadline = (next_t <= t) ? t + 64'(period) : next_t;
      end
      if (take) begin
        anchored   = 1'b1;
        n_consumed = bump(n_consumed);
      end else begin
        n_dropped = bump(n_dropped);
      end
      if (hold_sum > ~63'd0 - 63'(f.held_us))
        hold_sum = ~63'd0;
      else
        hold_sum = hold_sum + 63'(f.held_us);
      n_samples = bump(n_samples);
      if (f.held_us > hold_peak) hold_peak = f.held_us;
    end
    r.consumed        = take;
    r.consumed_total  = n_consumed;
    r.dropped_total   = n_dropped;
    r.latency_sum_us  = hold_sum;
    r.latency_count   = n_samples;
    r.latency_peak_us = hold_peak;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pace_mode    = MODE_WALLCLOCK;
      period       = '0;
      sink_is_open = 1'b0;
      clear_stats();
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[3:2])
          REG_PACING_MODE: pace_mode = pwdata[0];
          REG_PERIOD_NS:   period    = pwdata;
          REG_SINK_OPEN: begin
            sink_is_open = pwdata[0];
            if (pwdata[0]) clear_stats();
            else anchored = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) due_results.push_back(pace_frame(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $error("result beat with no frame pending");
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("consumed", 64'(want.consumed), 64'(out_data.consumed));
          check_field("consumed_total", 64'(want.consumed_total),
                      64'(out_data.consumed_total));
          check_field("dropped_total", 64'(want.dropped_total),
                      64'(out_data.dropped_total));
          check_field("latency_sum_us", 64'(want.latency_sum_us),
                      64'(out_data.latency_sum_us));
          check_field("latency_count", 64'(want.latency_count),
                      64'(out_data.latency_count));
          check_field("latency_peak_us", 64'(want.latency_peak_us),
                      64'(out_data.latency_peak_us));
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import dfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          FRAME_GOAL  = 1900;
  localparam logic [62:0] MAX_ARRIVAL = {63{1'b1}};

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr     = '0;
  logic [CFG_DATA_BITS-1:0] pwdata    = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int mismatches;
  int outstanding;
  int cycles        = 0;
  int sent          = 0;
  bit steady        = 1'b0;
  bit squeeze_req   = 1'b0;
  bit squeeze_done  = 1'b0;

  deadline_frame_pacer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pacer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [62:0] arrival, input logic [31:0] held,
                            input logic ok);
    int gap;
    int r;
    in_valid            <= 1'b1;
    in_data.arrival_ns  <= arrival;
    in_data.held_us     <= held;
    in_data.frame_valid <= ok;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 19);
      if (r >= 18) gap = $urandom_range(10, 40);
      else if (r >= 12) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int r;
    int n;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 10) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 12);
        end else if (r < 16) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 18) begin
          out_stall <= 1'b1;
          n = $urandom_range(8, 40);
        end else begin
          out_stall <= 1'b0;
          n = $urandom_range(40, 150);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    logic [63:0] now_ns;
    logic [63:0] step;
    logic [63:0] per64;
    logic [63:0] noise;
    logic [62:0] arrival;
    logic [31:0] held;
    logic [31:0] cur_period;
    logic        ok;
    int          phase_len;
    int          phase;
    int          r;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sink still closed after reset
    send_frame(63'd0, 32'd0, 1'b1);
    send_frame(63'd77, 32'd5, 1'b0);
    settle();

    write_reg(REG_PACING_MODE, 32'(MODE_WALLCLOCK));
    write_reg(REG_PERIOD_NS, 32'd1000);
    write_reg(REG_SINK_OPEN, 32'd1);
    send_frame(63'd5000, 32'd7, 1'b1);
    send_frame(63'd5999, 32'd12, 1'b1);
    send_frame(63'd6000, 32'd3, 1'b1);
    send_frame(63'd20000, 32'd0, 1'b1);
    send_frame(63'd20500, 32'd9, 1'b0);
    send_frame(63'd10, 32'd4, 1'b1);
    send_frame(63'd21000, 32'hFFFF_FFFF, 1'b1);
    settle();

    // zero period: each consumed frame re-anchors on itself
    write_reg(REG_PERIOD_NS, 32'd0);
    send_frame(63'd30000, 32'd1, 1'b1);
    send_frame(63'd30000, 32'd2, 1'b1);
    send_frame(63'd29999, 32'd3, 1'b1);
    send_frame(MAX_ARRIVAL, 32'd4, 1'b1);
    settle();

    write_reg(REG_PERIOD_NS, 32'hFFFF_FFFF);
    write_reg(REG_SINK_OPEN, 32'd1);
    send_frame(MAX_ARRIVAL, 32'd5, 1'b1);
    send_frame(MAX_ARRIVAL, 32'd6, 1'b1);
    send_frame(63'd0, 32'd7, 1'b1);
    settle();

    write_reg(REG_PACING_MODE, 32'(MODE_FREE));
    send_frame(63'd0, 32'd8, 1'b1);
    send_frame(63'd0, 32'd9, 1'b1);
    send_frame(63'd123, 32'd10, 1'b0);
    settle();

    // back to wallclock against the stale deadline
    write_reg(REG_PACING_MODE, 32'(MODE_WALLCLOCK));
    send_frame(63'd1000, 32'd11, 1'b1);
    settle();

    write_reg(REG_SINK_OPEN, 32'd0);
    send_frame(63'd5, 32'd1, 1'b1);
    send_frame(63'd6, 32'd2, 1'b0);
    settle();

    cur_period = 32'hFFFF_FFFF;
    now_ns     = 64'd0;
    phase      = 0;
    while (sent < FRAME_GOAL) begin
      settle();
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(REG_PACING_MODE,
                  ($urandom_range(0, 3) == 0) ? 32'(MODE_FREE) : 32'(MODE_WALLCLOCK));
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       cur_period = 32'd0;
          1:       cur_period = 32'd1;
          2:       cur_period = 32'hFFFF_FFFF;
          3:       cur_period = $urandom;
          4, 5:    cur_period = $urandom_range(1000, 100000);
          default: cur_period = $urandom_range(2, 5000);
        endcase
        write_reg(REG_PERIOD_NS, cur_period);
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        write_reg(REG_SINK_OPEN, 32'd0);
      end else if (r > 2 || phase == 0) begin
        write_reg(REG_SINK_OPEN, 32'd1);
        if ($urandom_range(0, 3) == 0)
          now_ns = {2'b00, $urandom, 30'($urandom_range(0, 2**30 - 1))};
        else now_ns = 64'($urandom_range(0, 100000));
      end
      per64 = 64'(cur_period);

      if (phase == 0) begin
        steady      = 1'b1;
        phase_len   = 200;
        squeeze_req = 1'b1;
      end else begin
        steady    = ($urandom_range(0, 3) == 0);
        phase_len = $urandom_range(20, 120);
      end

      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0:       step = 64'd0;
          1:       step = (per64 == 0) ? 64'd0 : per64 - 64'd1;
          2, 3:    step = per64;
          4:       step = per64 + 64'($urandom_range(1, 50));
          5:       step = per64 / 2;
          6:       step = 64'($urandom_range(0, 2000));
          7:       step = 3 * per64 + 64'($urandom_range(0, 5000));
          8:       step = 64'($urandom);
          default: step = per64 + per64 / 4;
        endcase
        now_ns  = now_ns + step;
        arrival = now_ns[62:0];
        r = $urandom_range(0, 15);
        if (r == 0) begin
          noise   = {$urandom, $urandom};
          arrival = noise[62:0];
        end else if (r == 1) begin
          arrival = now_ns[62:0] - 63'($urandom_range(1, 1000));
        end
        case ($urandom_range(0, 7))
          0:       held = 32'd0;
          1:       held = 32'hFFFF_FFFF;
          2, 3:    held = $urandom_range(0, 1000);
          default: held = $urandom;
        endcase
        ok = ($urandom_range(0, 11) != 0);
        send_frame(arrival, held, ok);
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (outstanding != 0) $error("%0d results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[deadline_frame_pacer.f]
rtl/dfp_pkg.sv
rtl/dfp_cfg.sv
rtl/dfp_core.sv
rtl/deadline_frame_pacer.sv
tb/sv/pacer_checker.sv
tb/sv/tb_top.sv
